// ----- src/pth_sensor_compensation_defines.svh -----
// assertion macros for the sensor compensation block
// used by the checker bound to the top level; no other dependencies
`ifndef PTH_SENSOR_COMPENSATION_DEFINES_SVH
`define PTH_SENSOR_COMPENSATION_DEFINES_SVH

// property that must hold in the cycle after the antecedent
`define PTHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pthc check failed");

// property that must hold on every edge out of reset
`define PTHC_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pthc check failed");

`endif

// ----- src/pthc_pkg.sv -----
// shared types, constants and helpers for the sensor compensation block
// no dependencies
`default_nettype none

package pthc_pkg;

    localparam int QUEUE_DEPTH = 2;

    // raw sample word
    typedef struct packed {
        logic [19:0] p;
        logic [19:0] t;
        logic [15:0] h;
    } t_raw;

    // trim register set
    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] pa;
        logic [47:0] pb;
        logic [47:0] pc;
        logic [31:0] ha;
        logic [39:0] hb;
    } t_trim;

    // result word
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic [13:0] hum;
    } t_result;

    // register index codes
    typedef enum logic [2:0] {
        REG_TEMP  = 3'd0,
        REG_PA    = 3'd1,
        REG_PB    = 3'd2,
        REG_PC    = 3'd3,
        REG_HA    = 3'd4,
        REG_HB    = 3'd5
    } t_reg_idx;

    // sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE, ST_T0, ST_T1, ST_T2, ST_T3,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_PDIVSET, ST_PDIV, ST_P7, ST_P8, ST_P9,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8,
        ST_DONE
    } t_step;

    localparam logic [31:0] K_P_OFFSET  = 32'd64000;
    localparam logic [31:0] K_P_FULL    = 32'd1048576;
    localparam logic [31:0] K_P_SCALE   = 32'd3125;
    localparam logic [31:0] K_DIV_SPLIT = 32'h8000_0000;
    localparam logic [31:0] K_H_OFFSET  = 32'd76800;
    localparam logic [31:0] K_H_MAX     = 32'd419430400;
    localparam logic [31:0] K_H_ROUND   = 32'd16384;
    localparam logic [31:0] K_H_BIAS    = 32'd2097152;
    localparam logic [31:0] K_H_ROUND2  = 32'd8192;
    localparam logic [31:0] K_HALF      = 32'd32768;
    localparam logic [31:0] K_T_ROUND   = 32'd128;
    localparam logic [31:0] K_PCT       = 32'd100;
    localparam logic [31:0] K_FIVE      = 32'd5;

    // arithmetic right shift on a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

`default_nettype wire

// ----- src/pthc_front.sv -----
// front end: accepts raw sample words into a short queue
// depends on pthc_pkg
`default_nettype none

module pthc_front #(
    parameter int DEPTH = pthc_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pthc_pkg::t_raw i_raw,
    output logic               o_valid,
    output pthc_pkg::t_raw     o_raw,
    input  wire logic          i_pop
);
    import pthc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_raw          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_raw   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_raw;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/pthc_div.sv -----
// iterative unsigned 32 by 32 divider, one quotient bit per cycle
// depends on pthc_pkg
`default_nettype none

module pthc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    import pthc_pkg::*;

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_den;
    logic [32:0] w_sh, w_diff;

    assign w_sh   = {r_rem, r_quo[31]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quo;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
            end else begin
                r_rem <= w_sh[31:0];
            end
            r_quo <= {r_quo[30:0], ~w_diff[32]};
        end
    end

endmodule

`default_nettype wire

// ----- src/pthc_back.sv -----
// back end: sequencer over one shared multiplier and the divider
// depends on pthc_pkg and pthc_div
`default_nettype none

module pthc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pthc_pkg::t_trim   i_trim,
    input  wire logic              i_valid,
    input  wire pthc_pkg::t_raw    i_raw,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output pthc_pkg::t_result      o_result
);
    import pthc_pkg::*;

    t_step       r_step, n_step;
    t_raw        r_raw, n_raw;
    logic [31:0] r_a, n_a, r_b, n_b, r_d, n_d, r_x, n_x;
    logic [31:0] r_fine, n_fine, r_h, n_h, r_hb, n_hb;
    logic [31:0] r_temp, n_temp, r_pres, n_pres;
    logic [13:0] r_hum, n_hum;
    logic        r_dbl, n_dbl;
    logic        r_ov;
    t_result     r_out;
    logic        w_load;

    logic [31:0] m_a, m_b, w_prod, w_hv;
    logic [63:0] w_full;
    logic        w_start;
    logic [31:0] w_dividend;
    logic        w_done;
    logic [31:0] w_quot;

    // trim fields
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, i_trim.temp[15:0]};
    assign t2 = sx16(i_trim.temp[31:16]);
    assign t3 = sx16(i_trim.temp[47:32]);
    assign p1 = {16'd0, i_trim.pa[15:0]};
    assign p2 = sx16(i_trim.pa[31:16]);
    assign p3 = sx16(i_trim.pa[47:32]);
    assign p4 = sx16(i_trim.pb[15:0]);
    assign p5 = sx16(i_trim.pb[31:16]);
    assign p6 = sx16(i_trim.pb[47:32]);
    assign p7 = sx16(i_trim.pc[15:0]);
    assign p8 = sx16(i_trim.pc[31:16]);
    assign p9 = sx16(i_trim.pc[47:32]);
    assign h1 = {24'd0, i_trim.ha[7:0]};
    assign h2 = sx16(i_trim.ha[23:8]);
    assign h3 = {24'd0, i_trim.ha[31:24]};
    assign h4 = sx16(i_trim.hb[15:0]);
    assign h5 = sx16(i_trim.hb[31:16]);
    assign h6 = sx8(i_trim.hb[39:32]);

    // shared multiplier, low word kept
    assign w_full = m_a * m_b;
    assign w_prod = w_full[31:0];

    assign w_load   = (r_step == ST_DONE) && (!r_ov || i_ready);
    assign o_pop    = (r_step == ST_IDLE) && i_valid;
    assign o_valid  = r_ov;
    assign o_result = r_out;

    pthc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_a),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    // next step
    always_comb begin
        n_step = r_step;
        unique case (r_step)
            ST_IDLE:    if (i_valid) n_step = ST_T0;
            ST_T0:      n_step = ST_T1;
            ST_T1:      n_step = ST_T2;
            ST_T2:      n_step = ST_T3;
            ST_T3:      n_step = ST_P0;
            ST_P0:      n_step = ST_P1;
            ST_P1:      n_step = ST_P2;
            ST_P2:      n_step = ST_P3;
            ST_P3:      n_step = ST_P4;
            ST_P4:      n_step = ST_P5;
            ST_P5:      n_step = ST_P6;
            ST_P6:      n_step = ST_PDIVSET;
            ST_PDIVSET: n_step = (r_a == '0) ? ST_H0 : ST_PDIV;
            ST_PDIV:    if (w_done) n_step = ST_P7;
            ST_P7:      n_step = ST_P8;
            ST_P8:      n_step = ST_P9;
            ST_P9:      n_step = ST_H0;
            ST_H0:      n_step = ST_H1;
            ST_H1:      n_step = ST_H2;
            ST_H2:      n_step = ST_H3;
            ST_H3:      n_step = ST_H4;
            ST_H4:      n_step = ST_H5;
            ST_H5:      n_step = ST_H6;
            ST_H6:      n_step = ST_H7;
            ST_H7:      n_step = ST_H8;
            ST_H8:      n_step = ST_DONE;
            ST_DONE:    if (w_load) n_step = ST_IDLE;
            default:    n_step = ST_IDLE;
        endcase
    end

    // multiplier operands and divider start per step
    always_comb begin
        m_a        = '0;
        m_b        = '0;
        w_start    = 1'b0;
        w_dividend = (r_pres < K_DIV_SPLIT) ? {r_pres[30:0], 1'b0} : r_pres;
        unique case (r_step)
            ST_T0: begin
                m_a = {15'd0, r_raw.t[19:3]} - {15'd0, t1[15:0], 1'b0};
                m_b = t2;
            end
            ST_T1:      begin m_a = r_d;                 m_b = r_d;                 end
            ST_T2:      begin m_a = r_d;                 m_b = t3;                  end
            ST_T3:      begin m_a = r_fine;              m_b = K_FIVE;              end
            ST_P0:      begin m_a = asr(r_a, 5'd2);      m_b = asr(r_a, 5'd2);      end
            ST_P1:      begin m_a = asr(r_d, 5'd11);     m_b = p6;                  end
            ST_P2:      begin m_a = r_a;                 m_b = p5;                  end
            ST_P3:      begin m_a = p3;                  m_b = asr(r_d, 5'd13);     end
            ST_P4:      begin m_a = p2;                  m_b = r_a;                 end
            ST_P5:      begin m_a = K_HALF + r_a;        m_b = p1;                  end
            ST_P6: begin
                m_a = (K_P_FULL - {12'd0, r_raw.p}) - asr(r_b, 5'd12);
                m_b = K_P_SCALE;
            end
            ST_PDIVSET: w_start = (r_a != '0);
            ST_P7:      begin m_a = r_pres >> 3;         m_b = r_pres >> 3;         end
            ST_P8:      begin m_a = p9;                  m_b = r_d;                 end
            ST_P9:      begin m_a = r_pres >> 2;         m_b = p8;                  end
            ST_H0:      begin m_a = h5;                  m_b = r_h;                 end
            ST_H1:      begin m_a = r_h;                 m_b = h6;                  end
            ST_H2:      begin m_a = r_h;                 m_b = h3;                  end
            ST_H3:      begin m_a = r_d;                 m_b = r_x;                 end
            ST_H4:      begin m_a = r_d;                 m_b = h2;                  end
            ST_H5:      begin m_a = r_hb;                m_b = r_d;                 end
            ST_H6:      begin m_a = asr(r_a, 5'd15);     m_b = asr(r_a, 5'd15);     end
            ST_H7:      begin m_a = r_d;                 m_b = h1;                  end
            ST_H8:      begin m_a = r_a >> 12;           m_b = K_PCT;               end
            default:    begin m_a = '0;                  m_b = '0;                  end
        endcase
    end

    // datapath register updates
    always_comb begin
        n_raw  = r_raw;
        n_a    = r_a;
        n_b    = r_b;
        n_d    = r_d;
        n_x    = r_x;
        n_fine = r_fine;
        n_h    = r_h;
        n_hb   = r_hb;
        n_temp = r_temp;
        n_pres = r_pres;
        n_hum  = r_hum;
        n_dbl  = r_dbl;
        w_hv   = r_a - asr(w_prod, 5'd4);
        case (r_step)
            ST_IDLE: n_raw = i_raw;
            ST_T0: begin
                n_a = asr(w_prod, 5'd11);
                n_d = {16'd0, r_raw.t[19:4]} - t1;
            end
            ST_T1: n_d = asr(w_prod, 5'd12);
            ST_T2: n_fine = r_a + asr(w_prod, 5'd14);
            ST_T3: begin
                n_temp = asr(w_prod + K_T_ROUND, 5'd8);
                n_a    = asr(r_fine, 5'd1) - K_P_OFFSET;
                n_h    = r_fine - K_H_OFFSET;
            end
            ST_P0: n_d = w_prod;
            ST_P1: n_b = w_prod;
            ST_P2: n_b = asr(r_b + {w_prod[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'd0};
            ST_P3: n_x = asr(w_prod, 5'd3);
            ST_P4: n_a = asr(r_x + asr(w_prod, 5'd1), 5'd18);
            ST_P5: n_a = asr(w_prod, 5'd15);
            ST_P6: n_pres = w_prod;
            ST_PDIVSET: begin
                n_dbl = !(r_pres < K_DIV_SPLIT);
                if (r_a == '0) begin
                    n_pres = '0;
                end
            end
            ST_PDIV: begin
                if (w_done) begin
                    n_pres = r_dbl ? {w_quot[30:0], 1'b0} : w_quot;
                end
            end
            ST_P7: n_d = w_prod >> 13;
            ST_P8: n_a = asr(w_prod, 5'd12);
            ST_P9: n_pres = r_pres + asr(r_a + asr(w_prod, 5'd13) + p7, 5'd4);
            ST_H0: begin
                n_hb = asr({2'd0, r_raw.h, 14'd0} - {h4[11:0], 20'd0} - w_prod
                           + K_H_ROUND, 5'd15);
            end
            ST_H1: n_d = asr(w_prod, 5'd10);
            ST_H2: n_x = asr(w_prod, 5'd11) + K_HALF;
            ST_H3: n_d = asr(w_prod, 5'd10) + K_H_BIAS;
            ST_H4: n_d = asr(w_prod + K_H_ROUND2, 5'd14);
            ST_H5: n_a = w_prod;
            ST_H6: n_d = asr(w_prod, 5'd7);
            ST_H7: begin
                // clamp to 0..100 %rh
                if (w_hv[31]) begin
                    n_a = '0;
                end else if (w_hv > K_H_MAX) begin
                    n_a = K_H_MAX;
                end else begin
                    n_a = w_hv;
                end
            end
            ST_H8: n_hum = w_prod[23:10];
            default: n_raw = r_raw;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_raw  <= n_raw;
        r_a    <= n_a;
        r_b    <= n_b;
        r_d    <= n_d;
        r_x    <= n_x;
        r_fine <= n_fine;
        r_h    <= n_h;
        r_hb   <= n_hb;
        r_temp <= n_temp;
        r_pres <= n_pres;
        r_hum  <= n_hum;
        r_dbl  <= n_dbl;
        if (w_load) begin
            r_out.temp <= r_temp;
            r_out.pres <= r_pres;
            r_out.hum  <= r_hum;
        end
    end

    // step and output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_ov   <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/pth_sensor_compensation.sv -----
// top level: trim registers on the apb port, front queue and back sequencer
// depends on pthc_pkg, pthc_front, pthc_back
//
// Each raw sample word gives one word with temperature in 0.01 degC, pressure
// in Pa and humidity in 0.01 %RH. From the head of the queue to the output
// register a word passes 23 multiply steps on one shared 32x32 multiplier and
// a divide step on a one-bit-per-cycle divider; when the pressure divisor term
// is zero, the divide step and the pressure steps after it are skipped. A queue
// of QUEUE_DEPTH words takes input while the sequencer works and while a
// finished word waits in the output register.
// Trims sit at byte address 8*i; write them only while the block is idle.
`default_nettype none

module pth_sensor_compensation #(
    parameter int QUEUE_DEPTH = pthc_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [19:0]        i_raw_pressure,
    input  wire logic [19:0]        i_raw_temperature,
    input  wire logic [15:0]        i_raw_humidity,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_temperature_centi,
    output logic [31:0]             o_pressure_pa,
    output logic [13:0]             o_humidity_centi
);
    import pthc_pkg::*;

    t_trim    r_trim;
    t_raw     w_in_raw, w_q_raw;
    t_result  w_res;
    t_reg_idx w_idx;
    logic     w_wr, w_q_valid, w_pop;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[5:3]);

    // trim register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TEMP: r_trim.temp <= pwdata[47:0];
                REG_PA:   r_trim.pa   <= pwdata[47:0];
                REG_PB:   r_trim.pb   <= pwdata[47:0];
                REG_PC:   r_trim.pc   <= pwdata[47:0];
                REG_HA:   r_trim.ha   <= pwdata[31:0];
                REG_HB:   r_trim.hb   <= pwdata[39:0];
                default:  r_trim      <= r_trim;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (w_idx)
            REG_TEMP: prdata = {16'd0, r_trim.temp};
            REG_PA:   prdata = {16'd0, r_trim.pa};
            REG_PB:   prdata = {16'd0, r_trim.pb};
            REG_PC:   prdata = {16'd0, r_trim.pc};
            REG_HA:   prdata = {32'd0, r_trim.ha};
            REG_HB:   prdata = {24'd0, r_trim.hb};
            default:  prdata = '0;
        endcase
    end

    assign w_in_raw.p = i_raw_pressure;
    assign w_in_raw.t = i_raw_temperature;
    assign w_in_raw.h = i_raw_humidity;

    pthc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_raw   (w_in_raw),
        .o_valid (w_q_valid),
        .o_raw   (w_q_raw),
        .i_pop   (w_pop)
    );

    pthc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_trim   (r_trim),
        .i_valid  (w_q_valid),
        .i_raw    (w_q_raw),
        .o_pop    (w_pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_res)
    );

    assign o_temperature_centi = $signed(w_res.temp);
    assign o_pressure_pa       = w_res.pres;
    assign o_humidity_centi    = w_res.hum;

endmodule

`default_nettype wire

// ----- src/pthc_checker.sv -----
// port-level checks for the sensor compensation block, bound to the top level
// depends on pth_sensor_compensation_defines.svh and pth_sensor_compensation
`default_nettype none
`include "pth_sensor_compensation_defines.svh"

module pthc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_temperature_centi,
    input wire logic [31:0] o_pressure_pa,
    input wire logic [13:0] o_humidity_centi,
    input wire logic        psel,
    input wire logic        pready
);

    // stalled word stays
    `PTHC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    // stalled word keeps its payload
    `PTHC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready,
        $stable(o_temperature_centi) && $stable(o_pressure_pa) && $stable(o_humidity_centi))
    // humidity never exceeds full scale
    `PTHC_ASSERT_NOW(a_hum_range, !o_out_valid || (o_humidity_centi <= 14'd10000))
    // apb port never waits
    `PTHC_ASSERT_NOW(a_pready, !psel || pready)

endmodule

bind pth_sensor_compensation pthc_checker u_pthc_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_pth_sensor_compensation.sv -----
// testbench for the sensor compensation block: apb trim writes, raw sample words
// with random bursts and stalls, checked against a built-in compensation predictor
// depends on pthc_pkg and pth_sensor_compensation
`timescale 1ns / 1ps
`default_nettype none

module tb_pth_sensor_compensation;
    import pthc_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [19:0] p;
        logic [19:0] t;
        logic [15:0] h;
    } t_sample;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] pres;
        logic [13:0] hum;
    } t_comp;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [19:0] i_raw_pressure;
    logic [19:0] i_raw_temperature;
    logic [15:0] i_raw_humidity;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [31:0] o_temperature_centi;
    logic [31:0] o_pressure_pa;
    logic [13:0] o_humidity_centi;

    // trim shadow used by the predictor
    logic [47:0] trim_t, trim_pa, trim_pb, trim_pc;
    logic [31:0] trim_ha;
    logic [39:0] trim_hb;

    t_sample pending_words[$];
    t_comp   expected_words[$];
    int      error_count;
    int      cycle_count;

    pth_sensor_compensation u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_raw_pressure(i_raw_pressure), .i_raw_temperature(i_raw_temperature),
        .i_raw_humidity(i_raw_humidity),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_temperature_centi(o_temperature_centi), .o_pressure_pa(o_pressure_pa),
        .o_humidity_centi(o_humidity_centi)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // arithmetic shift and sign extension helpers for the predictor
    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // compensation formulas, all terms wrap at 32 bits
    function automatic t_comp compensate(input t_sample s);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, fine, pres;
        t_comp r;
        t1 = {16'd0, trim_t[15:0]};   t2 = ext16(trim_t[31:16]);  t3 = ext16(trim_t[47:32]);
        p1 = {16'd0, trim_pa[15:0]};  p2 = ext16(trim_pa[31:16]); p3 = ext16(trim_pa[47:32]);
        p4 = ext16(trim_pb[15:0]);    p5 = ext16(trim_pb[31:16]); p6 = ext16(trim_pb[47:32]);
        p7 = ext16(trim_pc[15:0]);    p8 = ext16(trim_pc[31:16]); p9 = ext16(trim_pc[47:32]);
        h1 = {24'd0, trim_ha[7:0]};   h2 = ext16(trim_ha[23:8]);  h3 = {24'd0, trim_ha[31:24]};
        h4 = ext16(trim_hb[15:0]);    h5 = ext16(trim_hb[31:16]);
        h6 = {{24{trim_hb[39]}}, trim_hb[39:32]};

        // temperature
        a = sra((({12'd0, s.t} >> 3) - (t1 << 1)) * t2, 11);
        d = ({12'd0, s.t} >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        fine = a + b;
        r.temp = sra(fine * 32'd5 + 32'd128, 8);

        // pressure
        a = sra(fine, 1) - 32'd64000;
        d = sra(a, 2) * sra(a, 2);
        b = sra(d, 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(d, 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        if (a == 32'd0) begin
            pres = 32'd0;
        end else begin
            pres = ((32'd1048576 - {12'd0, s.p}) - sra(b, 12)) * 32'd3125;
            if (pres < 32'h8000_0000) pres = (pres << 1) / a;
            else pres = (pres / a) << 1;
            d = ((pres >> 3) * (pres >> 3)) >> 13;
            a = sra(p9 * d, 12);
            b = sra((pres >> 2) * p8, 13);
            pres = pres + sra(a + b + p7, 4);
        end
        r.pres = pres;

        // humidity
        a = fine - 32'd76800;
        b = sra(({16'd0, s.h} << 14) - (h4 << 20) - h5 * a + 32'd16384, 15);
        d = sra(a * h6, 10);
        d = sra(d * (sra(a * h3, 11) + 32'd32768), 10) + 32'd2097152;
        d = sra(d * h2 + 32'd8192, 14);
        a = b * d;
        d = sra(sra(a, 15) * sra(a, 15), 7);
        a = a - sra(d * h1, 4);
        if (a[31]) a = 32'd0;
        if (a > 32'd419430400) a = 32'd419430400;
        d = ((a >> 12) * 32'd100) >> 10;
        r.hum = d[13:0];
        return r;
    endfunction

    // apb write, setup then access
    task automatic trim_write(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 6'(int'(idx) * 8); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_TEMP: trim_t  = value[47:0];
            REG_PA:   trim_pa = value[47:0];
            REG_PB:   trim_pb = value[47:0];
            REG_PC:   trim_pc = value[47:0];
            REG_HA:   trim_ha = value[31:0];
            default:  trim_hb = value[39:0];
        endcase
    endtask

    // typical sensor trims with random spread, all-ones or all-zero trims, or fully random trims
    task automatic load_trims(input int mode);
        logic [63:0] v[6];
        if (mode == 0) begin
            v[0] = {16'd0, 16'hFC18, 16'h6800, 16'h6E00};
            v[1] = {16'd0, 16'h0BD0, 16'hD5F8, 16'h8F00};
            v[2] = {16'd0, 16'hFFF9, 16'h0100, 16'h1A00};
            v[3] = {16'd0, 16'h1770, 16'hF5E0, 16'h0030};
            v[4] = {32'd0, 8'h00, 16'h0168, 8'h4B};
            v[5] = {24'd0, 8'h1E, 16'h0032, 16'h0140};
            for (int i = 0; i < 6; i++) v[i] = v[i] ^ {$urandom_range(0, 63), $urandom_range(0, 63)};
            v[1][15:0] = 16'(16'h8F00 + $urandom_range(0, 4000));
        end else if (mode == 1) begin
            for (int i = 0; i < 6; i++) v[i] = '1;
        end else if (mode == 2) begin
            for (int i = 0; i < 6; i++) v[i] = '0;
        end else begin
            for (int i = 0; i < 6; i++) v[i] = {$urandom, $urandom};
        end
        for (int i = 0; i < 6; i++) trim_write(t_reg_idx'(i), v[i]);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample(input bit typical);
        t_sample s;
        if (typical) begin
            s.p = 20'($urandom_range(250000, 600000));
            s.t = 20'($urandom_range(400000, 600000));
            s.h = 16'($urandom_range(20000, 40000));
        end else begin
            s.p = 20'($urandom); s.t = 20'($urandom); s.h = 16'($urandom);
        end
        return s;
    endfunction

    task automatic s_drive(input t_sample s);
        i_in_valid <= 1'b1;
        i_raw_pressure <= s.p;
        i_raw_temperature <= s.t;
        i_raw_humidity <= s.h;
    endtask

    // stimulus
    initial begin
        t_sample s;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        trim_t = '0; trim_pa = '0; trim_pb = '0; trim_pc = '0; trim_ha = '0; trim_hb = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero trims give a zero divisor term
        s = '{20'd0, 20'd0, 16'd0};            pending_words.push_back(s);
        s = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF}; pending_words.push_back(s);
        wait_idle();

        // directed extremes on typical trims
        load_trims(0);
        s = '{20'd0, 20'd0, 16'd0};           pending_words.push_back(s);
        s = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF}; pending_words.push_back(s);
        s = '{20'd0, 20'hFFFFF, 16'd0};       pending_words.push_back(s);
        s = '{20'hFFFFF, 20'd0, 16'hFFFF};    pending_words.push_back(s);
        s = '{20'h55555, 20'hAAAAA, 16'h5555}; pending_words.push_back(s);
        s = '{20'hAAAAA, 20'h55555, 16'hAAAA}; pending_words.push_back(s);
        s = '{20'd415148, 20'd519888, 16'd27000}; pending_words.push_back(s);
        s = '{20'd415148, 20'd519888, 16'd65000}; pending_words.push_back(s);
        s = '{20'd415148, 20'd519888, 16'd100};   pending_words.push_back(s);
        // sender pause until everything is back
        wait_idle();

        // all-ones trims
        load_trims(1);
        for (int i = 0; i < 6; i++) pending_words.push_back(rand_sample(i[0]));
        wait_idle();

        // random phases over several trim sets
        for (int ph = 0; ph < 8; ph++) begin
            load_trims(ph % 3 == 2 ? 3 : 0);
            for (int i = 0; i < 175; i++) pending_words.push_back(rand_sample($urandom_range(0, 3) != 0));
            wait_idle();
        end

        while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_raw_pressure <= '0; i_raw_temperature <= '0; i_raw_humidity <= '0;
            burst_left <= 0; gap_left <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_words.push_back(compensate(pending_words.pop_front()));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_drive(pending_words[0]);
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    int stall_phase;
    int hold_count;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_phase <= 0;
            hold_count <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_count == 0 && expected_words.size() == 3 && stall_phase > 2000
                && stall_phase < 400000) begin
                hold_count <= 1;
            end
            if (hold_count > 0 && hold_count < 2000) begin
                hold_count <= hold_count + 1;
                i_out_ready <= 1'b0;
            end else if (stall_phase % 5000 < 1500) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end
            if (hold_count >= 2000) hold_count <= 2000;
        end
    end

    // monitor: compare each word with the oldest expectation
    always @(posedge i_clk) begin
        t_comp e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word temp=%0d pres=%0d hum=%0d", $realtime,
                         o_temperature_centi, o_pressure_pa, o_humidity_centi);
                error_count++;
            end else begin
                e = expected_words.pop_front();
                if (o_temperature_centi !== e.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $realtime,
                             $signed(e.temp), o_temperature_centi);
                    error_count++;
                end
                if (o_pressure_pa !== e.pres) begin
                    $display("%0t: pressure expected %0d actual %0d", $realtime,
                             e.pres, o_pressure_pa);
                    error_count++;
                end
                if (o_humidity_centi !== e.hum) begin
                    $display("%0t: humidity expected %0d actual %0d", $realtime,
                             e.hum, o_humidity_centi);
                    error_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        error_count = 0;
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/pthc_pkg.sv
src/pthc_front.sv
src/pthc_div.sv
src/pthc_back.sv
src/pth_sensor_compensation.sv
src/pthc_checker.sv
tb/sv/tb_pth_sensor_compensation.sv
